### src/windowed_rms_current_defines.svh
// Assertion macros shared by the windowed RMS current checker
`ifndef WINDOWED_RMS_CURRENT_DEFINES_SVH
`define WINDOWED_RMS_CURRENT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RMSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RMSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/rmsc_pkg.sv
// Types and constants of the windowed RMS current block
package rmsc_pkg;

	localparam int COUNT_BITS = 20;
	localparam int CHANNELS   = 2;
	localparam int CH_W       = 1;
	localparam int SAMPLE_W   = 16;
	localparam int CNT_W      = COUNT_BITS + 1;
	localparam int SQ_W       = 2 * SAMPLE_W - 1;
	localparam int SUM_W      = SQ_W + CNT_W - 1;
	localparam int MEAN_W     = SQ_W;
	localparam int FRAC_W     = 16;
	localparam int RAD_W      = ((MEAN_W + FRAC_W + 1) / 2) * 2;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int SREM_W     = ROOT_W + 2;
	localparam int GAIN_W     = 24;
	localparam int PROD_W     = ROOT_W + GAIN_W;
	localparam int RMS_W      = 23;
	localparam int OUT_DATA_W = 24;
	localparam int ITER_W     = 6;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;
	localparam int QLVL_W     = 3;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CNT_W-1:0] COUNT_LIMIT = {1'b1, {COUNT_BITS{1'b0}}};
	localparam logic [GAIN_W-1:0] GAIN_CH0_RST = 24'd48654;
	localparam logic [GAIN_W-1:0] GAIN_CH1_RST = 24'd24327;
	localparam logic [RMS_W-1:0] RMS_MAX = {RMS_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH0 = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH1 = 1'd1;

	// one closed window handed from the accumulator to the back end
	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
		logic             dropped;
	} window_t;

	typedef struct packed {
		logic not_empty;
		logic has_room;
	} queue_status_t;

endpackage

### src/windowed_rms_current.sv
// A closing sample's window is pushed into the four-entry window queue, where it may wait
// behind earlier windows; the back end then runs the bit-serial divider and square root,
// multiplies by the gain and registers the result. One sample per cycle into the
// accumulator while the queue has room; the back end finishes one window before the next.
// Reset (arst_n low, asynchronous): sums, counts, drop flags and queue cleared,
// gains back to their defaults; no reset sweep, samples are taken straight away.
module windowed_rms_current import rmsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,   // sample
	input  logic                  s_tuser,   // channel
	input  logic                  s_tlast,   // window_end
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // rms_current[22:0], zero pad
	output logic [1:0]            m_tuser,   // result_channel, overflow
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [GAIN_W-1:0]     cfg_data
);

	logic [GAIN_W-1:0] gain_ch0_q;
	logic [GAIN_W-1:0] gain_ch1_q;
	queue_status_t     q_status;
	logic              push;
	window_t           push_data;
	logic              pop;
	window_t           pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_ch0_q <= GAIN_CH0_RST;
			gain_ch1_q <= GAIN_CH1_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_CH0: gain_ch0_q <= cfg_data;
				REG_GAIN_CH1: gain_ch1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rmsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	rmsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	rmsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_data   (pop_data),
		.pop      (pop),
		.gain_ch0 (gain_ch0_q),
		.gain_ch1 (gain_ch1_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

### src/rmsc_front.sv
// Front end: squares samples and keeps per-channel sums, counts and drop flags
module rmsc_front import rmsc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,  // sample
	input  logic                s_tuser,  // channel
	input  logic                s_tlast,  // window_end
	input  queue_status_t       q_status,
	output logic                push,
	output window_t             push_data
);

	logic              valid_s1;
	logic [CH_W-1:0]   ch_s1;
	logic              last_s1;
	logic [SQ_W-1:0]   sq_s1;

	logic [SUM_W-1:0]  sum_q  [CHANNELS];
	logic [CNT_W-1:0]  cnt_q  [CHANNELS];
	logic              drop_q [CHANNELS];

	logic [SAMPLE_W-1:0]   mag;
	logic [2*SAMPLE_W-1:0] sq_full;
	logic                  take;
	logic [SUM_W-1:0]      sum_new;
	logic [CNT_W-1:0]      cnt_new;
	logic                  drop_new;
	logic                  at_limit;

	// room is checked against the registered level; one closing request may sit in s1
	assign s_tready = q_status.has_room;
	assign take     = s_tvalid && s_tready;

	// 0x8000 maps to 0x8000, which still fits unsigned
	assign mag     = s_tdata[SAMPLE_W-1] ? (~s_tdata + SAMPLE_W'(1)) : s_tdata;
	assign sq_full = mag * mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ch_s1   <= s_tuser;
			last_s1 <= s_tlast;
			sq_s1   <= sq_full[SQ_W-1:0];
		end
	end

	always_comb begin
		at_limit = (cnt_q[ch_s1] == COUNT_LIMIT);
		if (at_limit) begin
			sum_new  = sum_q[ch_s1];
			cnt_new  = cnt_q[ch_s1];
			drop_new = 1'b1;
		end else begin
			sum_new  = sum_q[ch_s1] + SUM_W'(sq_s1);
			cnt_new  = cnt_q[ch_s1] + CNT_W'(1);
			drop_new = drop_q[ch_s1];
		end
	end

	assign push              = valid_s1 && last_s1;
	assign push_data.ch      = ch_s1;
	assign push_data.sum     = sum_new;
	assign push_data.count   = cnt_new;
	assign push_data.dropped = drop_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i]  <= '0;
				cnt_q[i]  <= '0;
				drop_q[i] <= 1'b0;
			end
		end else if (valid_s1) begin
			if (last_s1) begin
				sum_q[ch_s1]  <= '0;
				cnt_q[ch_s1]  <= '0;
				drop_q[ch_s1] <= 1'b0;
			end else begin
				sum_q[ch_s1]  <= sum_new;
				cnt_q[ch_s1]  <= cnt_new;
				drop_q[ch_s1] <= drop_new;
			end
		end
	end

endmodule

### src/rmsc_queue.sv
// Short queue of closed windows between front and back end
module rmsc_queue import rmsc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  window_t       push_data,
	input  logic          pop,
	output window_t       pop_data,
	output queue_status_t status
);

	window_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QLVL_W-1:0] level_q;

	assign pop_data         = mem_q[rd_ptr_q];
	assign status.not_empty = (level_q != '0);
	assign status.has_room  = (level_q <= QLVL_W'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + QLVL_W'(1);
				2'b01:   level_q <= level_q - QLVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

### src/rmsc_back.sv
// Back end: restoring divide, digit-by-digit root, gain multiply, saturate
module rmsc_back import rmsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  queue_status_t         q_status,
	input  window_t               q_data,
	output logic                  pop,
	input  logic [GAIN_W-1:0]     gain_ch0,
	input  logic [GAIN_W-1:0]     gain_ch1,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // rms_current, zero pad
	output logic [1:0]            m_tuser   // result_channel, overflow
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_SQRT = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CH_W-1:0]    ch_q;
	logic               drop_q;
	logic [SUM_W-1:0]   num_q;
	logic [CNT_W-1:0]   den_q;
	logic [CNT_W-1:0]   rem_q;
	logic [MEAN_W-1:0]  quo_q;
	logic [ITER_W-1:0]  iter_q;
	logic [RAD_W-1:0]   rad_q;
	logic [SREM_W-1:0]  srem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [PROD_W-1:0]  prod_q;
	logic               out_valid_q;
	logic [RMS_W-1:0]   out_rms_q;
	logic               out_ch_q;
	logic               out_ovf_q;

	logic [CNT_W:0]     div_trial;
	logic               div_ge;
	logic [CNT_W-1:0]   rem_next;
	logic [MEAN_W-1:0]  quo_next;
	logic [MEAN_W-1:0]  mean;
	logic [SREM_W+1:0]  sq_trial;
	logic [SREM_W+1:0]  sq_sub;
	logic               sq_ge;
	logic [GAIN_W-1:0]  gain_sel;
	logic               out_free;
	logic               sat;

	assign div_trial = {rem_q, num_q[SUM_W-1]};
	assign div_ge    = (div_trial >= {1'b0, den_q});
	assign rem_next  = div_ge ? CNT_W'(div_trial - {1'b0, den_q}) : div_trial[CNT_W-1:0];
	assign quo_next  = {quo_q[MEAN_W-2:0], div_ge};
	// an empty window reads as a zero mean
	assign mean      = (den_q == '0) ? '0 : quo_next;

	assign sq_trial  = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign sq_sub    = {2'b00, root_q, 2'b01};
	assign sq_ge     = (sq_trial >= sq_sub);

	assign gain_sel  = (ch_q == CH_W'(0)) ? gain_ch0 : gain_ch1;
	assign out_free  = !out_valid_q || m_tready;
	assign sat       = |prod_q[PROD_W-1:FRAC_W+RMS_W];
	assign pop       = (state_q == ST_IDLE) && q_status.not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_status.not_empty) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (iter_q == '0) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (iter_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ch_q   <= q_data.ch;
				drop_q <= q_data.dropped;
				num_q  <= q_data.sum;
				den_q  <= q_data.count;
				rem_q  <= '0;
				quo_q  <= '0;
				iter_q <= ITER_W'(SUM_W - 1);
			end
			ST_DIV: begin
				rem_q  <= rem_next;
				quo_q  <= quo_next;
				num_q  <= {num_q[SUM_W-2:0], 1'b0};
				if (iter_q == '0) begin
					rad_q  <= RAD_W'({mean, {FRAC_W{1'b0}}});
					srem_q <= '0;
					root_q <= '0;
					iter_q <= ITER_W'(ROOT_W - 1);
				end else begin
					iter_q <= iter_q - ITER_W'(1);
				end
			end
			ST_SQRT: begin
				srem_q <= sq_ge ? SREM_W'(sq_trial - sq_sub) : SREM_W'(sq_trial);
				root_q <= {root_q[ROOT_W-2:0], sq_ge};
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				iter_q <= iter_q - ITER_W'(1);
			end
			ST_MUL: begin
				prod_q <= root_q * gain_sel;
			end
			ST_DONE: begin
				if (out_free) begin
					out_rms_q <= sat ? RMS_MAX : prod_q[FRAC_W +: RMS_W];
					out_ch_q  <= ch_q[0];
					out_ovf_q <= drop_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'(out_rms_q);
	assign m_tuser  = {out_ovf_q, out_ch_q};

endmodule

### src/rmsc_checker.sv
// Port-level checks on the windowed RMS current block, bound to the top level
`include "windowed_rms_current_defines.svh"

module rmsc_checker import rmsc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]            m_tuser
);

	// a stalled result keeps its value
	`RMSC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// pad bits above the current stay clear
	`RMSC_ASSERT_NOW(a_out_pad, clk, arst_n, m_tvalid, m_tdata[OUT_DATA_W-1:RMS_W] == '0, "tdata pad bit set")

	// an offered result carries no unknown bits
	`RMSC_ASSERT_NOW(a_out_known, clk, arst_n, m_tvalid, !$isunknown(m_tdata) && !$isunknown(m_tuser), "unknown bits in result")

	// handshake outputs are always driven out of reset
	`RMSC_ASSERT_NOW(a_hs_known, clk, arst_n, 1'b1, !$isunknown(s_tready) && !$isunknown(m_tvalid), "unknown handshake output")

endmodule

bind windowed_rms_current rmsc_checker u_rmsc_checker (.*);
